/* rtl/wsrq_pkg.sv */
// shared types and codes for the work-stealing run queue block
// no dependencies
`default_nettype none

package wsrq_pkg;

   localparam int NUM_PROCS_DEF   = 8;
   localparam int QUEUE_DEPTH_DEF = 128;
   localparam int TASK_BITS_DEF   = 16;

   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_GET   = 2'd1;
   localparam logic [1:0] FUNC_STEAL = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_INVALID = 2'd3;

   localparam logic [5:0] MOVED_MAX = 6'd63;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  proc;
      logic [2:0]  victim;
      logic [15:0] task_id;
   } req_type;

   typedef struct packed {
      logic [15:0] task_out;
      logic [1:0]  status;
      logic [5:0]  moved_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_GET,
      S_TLOOK,
      S_MRD,
      S_MWR,
      S_WBV,
      S_WBT
   } state_type;

endpackage

`default_nettype wire

/* rtl/wsrq_task_ram.sv */
// task store: one write port, one read port with registered read data
// no dependencies
`default_nettype none

module wsrq_task_ram #(
   parameter int DEPTH = 1024,
   parameter int DATA_W = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/work_stealing_run_queues.sv */
// top level of the work-stealing run queues: sequencer, pointer memory, output register
// depends on wsrq_pkg and wsrq_task_ram
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   wsrq_pkg::req_type
//   rsp       out         rsp_valid / rsp_ready   wsrq_pkg::rsp_type
//
// one transaction at a time; ready only while the sequencer is idle
// put, invalid requests, and get or steal on an empty queue answer from the lookup step
// steal: each moved task is a read then a write of the task store
// reset clears the per-queue pointer valid bits; task store is not cleared
// a full output register stalls the lookup step and the final step until the result is taken
`default_nettype none

module work_stealing_run_queues #(
   parameter int NUM_PROCS   = wsrq_pkg::NUM_PROCS_DEF,
   parameter int QUEUE_DEPTH = wsrq_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_BITS   = wsrq_pkg::TASK_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wsrq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wsrq_pkg::rsp_type      rsp_data
);

   localparam int PW   = $clog2(NUM_PROCS);
   localparam int AW   = $clog2(QUEUE_DEPTH);
   localparam int TAW  = $clog2(NUM_PROCS * QUEUE_DEPTH);
   localparam int PTRW = 2 * AW;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TAW-1:0] slot_addr(input logic [PW-1:0] q,
                                                input logic [AW-1:0] s);
      return TAW'(TAW'(q) * TAW'(QUEUE_DEPTH) + TAW'(s));
   endfunction

   wsrq_pkg::state_type state_ff, state_in;
   wsrq_pkg::req_type   req_ff, req_in;
   wsrq_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;

   logic [AW-1:0]        qh_ff, qh_in, qt_ff, qt_in;
   logic [AW-1:0]        th_ff, th_in, tt_ff, tt_in;
   logic [AW-1:0]        half_ff, half_in, moved_ff, moved_in;
   logic [TASK_BITS-1:0] task_ff, task_in;

   // pointer memory, entry is {head, tail}
   logic [PTRW-1:0]      ptr_mem [NUM_PROCS];
   logic [NUM_PROCS-1:0] ptr_vld_ff;
   logic [PTRW-1:0]      ptr_rd_ff;
   logic                 ptr_hit_ff;
   logic                 ptr_rd_en, ptr_wr_en;
   logic [PW-1:0]        ptr_rd_addr, ptr_wr_addr;
   logic [PTRW-1:0]      ptr_wr_data;

   logic                 tm_wr_en, tm_rd_en;
   logic [TAW-1:0]       tm_wr_addr, tm_rd_addr;
   logic [TASK_BITS-1:0] tm_wr_data, tm_rd_data;

   logic [AW-1:0] cur_h, cur_t;
   logic [AW:0]   cur_occ;
   logic [AW:0]   cur_rest;
   logic [PW-1:0] qp, qv;
   logic          out_free;
   logic          bad_req;
   logic [5:0]    moved_sat;

   assign cur_h   = ptr_hit_ff ? ptr_rd_ff[PTRW-1:AW] : '0;
   assign cur_t   = ptr_hit_ff ? ptr_rd_ff[AW-1:0] : '0;
   assign cur_occ = (cur_t >= cur_h) ? ({1'b0, cur_t} - {1'b0, cur_h})
                  : ((AW+1)'(QUEUE_DEPTH) - {1'b0, cur_h} + {1'b0, cur_t});
   assign cur_rest = cur_occ - (AW+1)'(1);

   assign qp       = PW'(req_ff.proc);
   assign qv       = PW'(req_ff.victim);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign bad_req  = (req_ff.func != wsrq_pkg::FUNC_PUT && req_ff.func != wsrq_pkg::FUNC_GET
                      && req_ff.func != wsrq_pkg::FUNC_STEAL)
                   || (32'(req_ff.proc) >= NUM_PROCS)
                   || (req_ff.func == wsrq_pkg::FUNC_STEAL
                       && ((32'(req_ff.victim) >= NUM_PROCS) || req_ff.victim == req_ff.proc));
   assign moved_sat = (32'(moved_ff) > 32'(wsrq_pkg::MOVED_MAX)) ? wsrq_pkg::MOVED_MAX
                                                                  : 6'(moved_ff);

   assign req_ready = (state_ff == wsrq_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      qh_in       = qh_ff;
      qt_in       = qt_ff;
      th_in       = th_ff;
      tt_in       = tt_ff;
      half_in     = half_ff;
      moved_in    = moved_ff;
      task_in     = task_ff;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      ptr_rd_en   = 1'b0;
      ptr_rd_addr = '0;
      ptr_wr_en   = 1'b0;
      ptr_wr_addr = '0;
      ptr_wr_data = '0;
      tm_wr_en    = 1'b0;
      tm_wr_addr  = '0;
      tm_wr_data  = '0;
      tm_rd_en    = 1'b0;
      tm_rd_addr  = '0;

      case (state_ff)
         wsrq_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               ptr_rd_en   = 1'b1;
               ptr_rd_addr = (req_data.func == wsrq_pkg::FUNC_STEAL) ? PW'(req_data.victim)
                                                                     : PW'(req_data.proc);
               state_in    = wsrq_pkg::S_LOOK;
            end
         end
         wsrq_pkg::S_LOOK: begin
            if (out_free) begin
               state_in = wsrq_pkg::S_IDLE;
               rsp_load = 1'b1;
               rsp_in   = '{task_out: '0, status: wsrq_pkg::STAT_INVALID, moved_count: '0};
               if (!bad_req) begin
                  case (req_ff.func)
                     wsrq_pkg::FUNC_PUT: begin
                        if (next_slot(cur_t) == cur_h) begin
                           rsp_in.status = wsrq_pkg::STAT_FULL;
                        end else begin
                           tm_wr_en      = 1'b1;
                           tm_wr_addr    = slot_addr(qp, cur_t);
                           tm_wr_data    = TASK_BITS'(req_ff.task_id);
                           ptr_wr_en     = 1'b1;
                           ptr_wr_addr   = qp;
                           ptr_wr_data   = {cur_h, next_slot(cur_t)};
                           rsp_in.status = wsrq_pkg::STAT_OK;
                        end
                     end
                     wsrq_pkg::FUNC_GET: begin
                        if (cur_h == cur_t) begin
                           rsp_in.status = wsrq_pkg::STAT_EMPTY;
                        end else begin
                           rsp_load    = 1'b0;
                           tm_rd_en    = 1'b1;
                           tm_rd_addr  = slot_addr(qp, cur_h);
                           ptr_wr_en   = 1'b1;
                           ptr_wr_addr = qp;
                           ptr_wr_data = {next_slot(cur_h), cur_t};
                           state_in    = wsrq_pkg::S_GET;
                        end
                     end
                     wsrq_pkg::FUNC_STEAL: begin
                        if (cur_h == cur_t) begin
                           rsp_in.status = wsrq_pkg::STAT_EMPTY;
                        end else begin
                           rsp_load    = 1'b0;
                           tm_rd_en    = 1'b1;
                           tm_rd_addr  = slot_addr(qv, cur_h);
                           qh_in       = next_slot(cur_h);
                           qt_in       = cur_t;
                           half_in     = AW'(cur_rest >> 1);
                           ptr_rd_en   = 1'b1;
                           ptr_rd_addr = qp;
                           state_in    = wsrq_pkg::S_TLOOK;
                        end
                     end
                     default: begin
                        rsp_in.status = wsrq_pkg::STAT_INVALID;
                     end
                  endcase
               end
            end
         end
         wsrq_pkg::S_GET: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{task_out: 16'(tm_rd_data), status: wsrq_pkg::STAT_OK,
                            moved_count: '0};
               state_in = wsrq_pkg::S_IDLE;
            end
         end
         wsrq_pkg::S_TLOOK: begin
            task_in  = tm_rd_data;
            th_in    = cur_h;
            tt_in    = cur_t;
            moved_in = '0;
            state_in = wsrq_pkg::S_MRD;
         end
         wsrq_pkg::S_MRD: begin
            if (moved_ff < half_ff && next_slot(tt_ff) != th_ff) begin
               tm_rd_en   = 1'b1;
               tm_rd_addr = slot_addr(qv, qh_ff);
               state_in   = wsrq_pkg::S_MWR;
            end else begin
               state_in = wsrq_pkg::S_WBV;
            end
         end
         wsrq_pkg::S_MWR: begin
            tm_wr_en   = 1'b1;
            tm_wr_addr = slot_addr(qp, tt_ff);
            tm_wr_data = tm_rd_data;
            tt_in      = next_slot(tt_ff);
            qh_in      = next_slot(qh_ff);
            moved_in   = moved_ff + 1'b1;
            state_in   = wsrq_pkg::S_MRD;
         end
         wsrq_pkg::S_WBV: begin
            ptr_wr_en   = 1'b1;
            ptr_wr_addr = qv;
            ptr_wr_data = {qh_ff, qt_ff};
            state_in    = wsrq_pkg::S_WBT;
         end
         wsrq_pkg::S_WBT: begin
            if (out_free) begin
               ptr_wr_en   = 1'b1;
               ptr_wr_addr = qp;
               ptr_wr_data = {th_ff, tt_ff};
               rsp_load    = 1'b1;
               rsp_in      = '{task_out: 16'(task_ff), status: wsrq_pkg::STAT_OK,
                               moved_count: moved_sat};
               state_in    = wsrq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wsrq_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsrq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ptr_wr_en) begin
            ptr_vld_ff[ptr_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      qh_ff    <= qh_in;
      qt_ff    <= qt_in;
      th_ff    <= th_in;
      tt_ff    <= tt_in;
      half_ff  <= half_in;
      moved_ff <= moved_in;
      task_ff  <= task_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // pointer memory, registered read
   always_ff @(posedge clock) begin
      if (ptr_wr_en) begin
         ptr_mem[ptr_wr_addr] <= ptr_wr_data;
      end
      if (ptr_rd_en) begin
         ptr_rd_ff  <= ptr_mem[ptr_rd_addr];
         ptr_hit_ff <= ptr_vld_ff[ptr_rd_addr];
      end
   end

   wsrq_task_ram #(
      .DEPTH  (NUM_PROCS * QUEUE_DEPTH),
      .DATA_W (TASK_BITS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (tm_wr_en),
      .wr_addr (tm_wr_addr),
      .wr_data (tm_wr_data),
      .rd_en   (tm_rd_en),
      .rd_addr (tm_rd_addr),
      .rd_data (tm_rd_data)
   );

`ifndef SYNTH
   a_move_never_overfills: assert property (@(posedge clock) disable iff (reset)
      state_ff == wsrq_pkg::S_MWR |-> next_slot(tt_ff) != th_ff)
      else $error("steal move into a full thief queue");

   a_move_within_half: assert property (@(posedge clock) disable iff (reset)
      state_ff == wsrq_pkg::S_MWR |-> moved_ff < half_ff)
      else $error("steal moved more than half of the victim queue");

   a_fail_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != wsrq_pkg::STAT_OK
         |-> rsp_ff.task_out == '0 && rsp_ff.moved_count == '0)
      else $error("failed transaction carries a task or move count");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench for work_stealing_run_queues: put, get and steal traffic
// predicted by an in-bench model of the per-processor circular queues
// depends on wsrq_pkg and the work_stealing_run_queues rtl
`timescale 1ns / 1ps

module tb_top;
   import wsrq_pkg::*;

   localparam int          NP          = NUM_PROCS_DEF;
   localparam int          QD          = QUEUE_DEPTH_DEF;
   localparam logic [15:0] TASK_MASK   = 16'((32'd1 << TASK_BITS_DEF) - 1);
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam int          RANDOM_OPS  = 400;
   localparam int          STALL_LIMIT = 5000;
   localparam int          TAIL_CYCLES = 10;

   typedef struct {
      req_type op;
      bit      wait_idle;
   } issue_slot;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   issue_slot   ops_to_issue[$];
   issue_slot   next_op;
   rsp_type     owed_replies[$];
   rsp_type     want;

   logic [15:0] task_mem [NP][QD];
   int unsigned q_head [NP];
   int unsigned q_tail [NP];

   int unsigned ops_queued, ops_taken, replies_checked, bad_count;
   int unsigned n_put, n_get, n_steal, n_full, n_empty, n_invalid;
   int unsigned moved_total, moved_peak, thief_cut;
   int unsigned send_wait, recv_wait, quiet_cycles;
   bit          send_calm, recv_calm;

   work_stealing_run_queues u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_type apply_queue_op(req_type r);
      rsp_type     o;
      int unsigned t, v, half, moved;
      o        = '0;
      o.status = STAT_INVALID;
      t        = r.proc;
      v        = r.victim;
      if (r.func == FUNC_UNUSED || t >= NP) begin
         n_invalid++;
      end else if (r.func == FUNC_PUT) begin
         n_put++;
         if ((q_tail[t] + 1) % QD == q_head[t]) begin
            o.status = STAT_FULL;
            n_full++;
         end else begin
            task_mem[t][q_tail[t]] = r.task_id & TASK_MASK;
            q_tail[t] = (q_tail[t] + 1) % QD;
            o.status = STAT_OK;
         end
      end else if (r.func == FUNC_GET) begin
         n_get++;
         if (q_head[t] == q_tail[t]) begin
            o.status = STAT_EMPTY;
            n_empty++;
         end else begin
            o.task_out = task_mem[t][q_head[t]];
            q_head[t] = (q_head[t] + 1) % QD;
            o.status = STAT_OK;
         end
      end else begin
         n_steal++;
         if (v >= NP || v == t) begin
            n_invalid++;
         end else if (q_head[v] == q_tail[v]) begin
            o.status = STAT_EMPTY;
            n_empty++;
         end else begin
            o.task_out = task_mem[v][q_head[v]];
            q_head[v] = (q_head[v] + 1) % QD;
            half  = ((q_tail[v] + QD - q_head[v]) % QD) / 2;
            moved = 0;
            while (moved < half && (q_tail[t] + 1) % QD != q_head[t]) begin
               task_mem[t][q_tail[t]] = task_mem[v][q_head[v]];
               q_tail[t] = (q_tail[t] + 1) % QD;
               q_head[v] = (q_head[v] + 1) % QD;
               moved++;
            end
            if (moved < half) thief_cut++;
            moved_total += moved;
            if (moved > moved_peak) moved_peak = moved;
            o.moved_count = (moved > MOVED_MAX) ? MOVED_MAX : 6'(moved);
            o.status = STAT_OK;
         end
      end
      return o;
   endfunction

   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_op(input logic [1:0] f, input logic [2:0] p, input logic [2:0] v,
                         input logic [15:0] id, input bit hold);
      issue_slot s;
      s.op.func    = f;
      s.op.proc    = p;
      s.op.victim  = v;
      s.op.task_id = id;
      s.wait_idle  = hold;
      ops_to_issue.push_back(s);
      ops_queued++;
   endtask

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned exp_val);
      bad_count++;
      $display("mismatch in %s at response %0d: got %0d, expected %0d",
               what, replies_checked, got, exp_val);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            owed_replies.push_back(apply_queue_op(req_data));
            ops_taken++;
            send_wait = pick_gap(send_calm);
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (ops_to_issue.size() > 0 &&
                         !(ops_to_issue[0].wait_idle && owed_replies.size() != 0)) begin
               next_op = ops_to_issue.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_op.op;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_checked++;
            if (owed_replies.size() == 0) begin
               flag_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = owed_replies.pop_front();
               if (rsp_data.task_out !== want.task_out)
                  flag_mismatch("task_out", rsp_data.task_out, want.task_out);
               if (rsp_data.status !== want.status)
                  flag_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.moved_count !== want.moved_count)
                  flag_mismatch("moved_count", rsp_data.moved_count, want.moved_count);
            end
            recv_wait = pick_gap(recv_calm);
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         end else if (recv_wait == 0 && !recv_calm && $urandom_range(0, 15) == 0) begin
            recv_wait = pick_gap(recv_calm);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned   ep, kind, n, i, f;
      logic [2:0]    pa, pb, fa, fb;
      bit            hold;

      // directed: empty queues, field extremes, self steal, unused op, split steals
      add_op(FUNC_GET,    3'd0, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_STEAL,  3'd1, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_PUT,    3'd0, 3'd7, 16'hFFFF, 1'b0);
      add_op(FUNC_PUT,    3'd0, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_PUT,    3'd0, 3'd0, 16'hA5A5, 1'b0);
      add_op(FUNC_PUT,    3'd0, 3'd0, 16'h5A5A, 1'b0);
      add_op(FUNC_PUT,    3'd0, 3'd0, 16'h1234, 1'b0);
      add_op(FUNC_STEAL,  3'd0, 3'd0, 16'hFFFF, 1'b0);
      add_op(FUNC_UNUSED, 3'd7, 3'd7, 16'hFFFF, 1'b0);
      add_op(FUNC_STEAL,  3'd7, 3'd0, 16'h0000, 1'b1);
      add_op(FUNC_GET,    3'd7, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_GET,    3'd7, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_GET,    3'd7, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_STEAL,  3'd3, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_GET,    3'd0, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_GET,    3'd0, 3'd0, 16'h0000, 1'b0);
      add_op(FUNC_PUT,    3'd7, 3'd0, 16'hFFFF, 1'b0);
      add_op(FUNC_STEAL,  3'd0, 3'd7, 16'h0000, 1'b0);
      add_op(FUNC_GET,    3'd3, 3'd0, 16'h0000, 1'b0);

      // random episodes
      n  = ops_queued + RANDOM_OPS;
      ep = 0;
      while (ops_queued < n) begin
         kind = (ep == 0) ? 100 : (ep == 1) ? 101 : $urandom_range(0, 99);
         pa   = 3'($urandom);
         pb   = pa + 3'($urandom_range(1, 7));
         if (kind == 100 || kind < 3) begin
            // fill to overflow, then one large steal
            for (i = 0; i < 128 + $urandom_range(0, 2); i++)
               add_op(FUNC_PUT, pa, 3'($urandom), 16'($urandom), 1'b0);
            add_op(FUNC_STEAL, pb, pa, 16'($urandom), 1'b0);
            for (i = 0; i < $urandom_range(0, 3); i++)
               add_op(FUNC_GET, pb, 3'($urandom), 16'($urandom), 1'b0);
         end else if (kind == 101 || kind < 5) begin
            // thief fills up part way through the move, then drains
            for (i = 0; i < 130; i++)
               add_op(FUNC_PUT, pa, 3'($urandom), 16'($urandom), 1'b0);
            for (i = 0; i < 4; i++)
               add_op(FUNC_GET, pa, 3'($urandom), 16'($urandom), 1'b0);
            for (i = 0; i < 20; i++)
               add_op(FUNC_PUT, pb, 3'($urandom), 16'($urandom), 1'b0);
            add_op(FUNC_STEAL, pa, pb, 16'($urandom), 1'b1);
            for (i = 0; i < 12; i++)
               add_op(FUNC_GET, pa, 3'($urandom), 16'($urandom), 1'b0);
         end else if (kind < 15) begin
            // drain one queue past empty
            for (i = 0; i < $urandom_range(10, 40); i++)
               add_op(($urandom_range(0, 3) == 0) ? FUNC_STEAL : FUNC_GET,
                      ($urandom_range(0, 1) == 0) ? pa : pb, pa, 16'($urandom), 1'b0);
         end else begin
            // mixed traffic around two busy processors
            fa = pa;
            fb = pb;
            for (i = 0; i < $urandom_range(5, 20); i++) begin
               f    = $urandom_range(0, 99);
               pa   = ($urandom_range(0, 3) != 0) ? (($urandom_range(0, 1) != 0) ? fa : fb)
                                                 : 3'($urandom);
               pb   = ($urandom_range(0, 3) != 0) ? (($urandom_range(0, 1) != 0) ? fb : fa)
                                                 : 3'($urandom);
               hold = ($urandom_range(0, 49) == 0);
               if (f < 45)
                  add_op(FUNC_PUT, pa, pb, 16'($urandom), hold);
               else if (f < 70)
                  add_op(FUNC_GET, pa, pb, 16'($urandom), hold);
               else if (f < 95)
                  add_op(FUNC_STEAL, pa, pb, 16'($urandom), hold);
               else
                  add_op(FUNC_UNUSED, pa, pb, 16'($urandom), hold);
            end
         end
         ep++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (ops_to_issue.size() != 0 || req_valid || owed_replies.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d puts, %0d gets, %0d steals; %0d moved, peak %0d, %0d cut short",
               n_put, n_get, n_steal, moved_total, moved_peak, thief_cut);
      $display("%0d full, %0d empty, %0d invalid; %0d responses checked, %0d mismatches",
               n_full, n_empty, n_invalid, replies_checked, bad_count);
      if (bad_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/wsrq_pkg.sv
rtl/wsrq_task_ram.sv
rtl/work_stealing_run_queues.sv
verif/tb_top.sv
